### hw/rtl/routing_mask_fnv_digest_unit_macros.svh
// assertion macros for the routing mask digest unit
`ifndef ROUTING_MASK_FNV_DIGEST_UNIT_MACROS_SVH
`define ROUTING_MASK_FNV_DIGEST_UNIT_MACROS_SVH

// same-cycle implication, checked on clk outside reset
`define RMFD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define RMFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/rmfd_pkg.sv
// shared types, constants and helpers for the routing mask digest unit
package rmfd_pkg;

  // item field widths
  localparam int ACT_W  = 2;
  localparam int VAL_W  = 64;
  localparam int CNT64_W = 64;
  localparam int PEND_W = 9;

  typedef logic [ACT_W-1:0]   action_t;
  typedef logic [VAL_W-1:0]   value_t;
  typedef logic [CNT64_W-1:0] count64_t;
  typedef logic [PEND_W-1:0]  pend_t;

  // action codes
  localparam action_t ACT_MASK     = 2'd0;
  localparam action_t ACT_FOLD_END = 2'd1;
  localparam action_t ACT_PLAIN    = 2'd2;

  // fnv-1a offset basis
  localparam value_t FNV_BASIS = 64'hcbf29ce484222325;

  // bytes folded per item and the byte counter width
  localparam int BYTES = VAL_W / 8;
  localparam int CNT_W = $clog2(BYTES);

  // pending bit count saturates at min(words * 32, field max)
  localparam int MAX_MASK_WORDS = 8;
  localparam int MASK_W         = 32;
  localparam int PEND_FIELD_MAX = (1 << PEND_W) - 1;
  localparam int PEND_CAP_RAW   = MAX_MASK_WORDS * MASK_W;
  localparam int PEND_CAP_INT   = (PEND_CAP_RAW > PEND_FIELD_MAX) ? PEND_FIELD_MAX
                                                                  : PEND_CAP_RAW;
  localparam pend_t PEND_CAP    = PEND_W'(PEND_CAP_INT);

  // per-item set bit count, 0..32
  localparam int IBITS_W = $clog2(MASK_W + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_HOLD
  } st_t;

  // set bits in one byte
  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + 4'(b[i]);
    end
    return n;
  endfunction

endpackage

### hw/rtl/rmfd_if.sv
// valid/ready channels for input items and result items
interface rmfd_in_if import rmfd_pkg::*;;
  logic    valid;
  logic    ready;
  action_t action;
  value_t  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface rmfd_out_if import rmfd_pkg::*;;
  logic     valid;
  logic     ready;
  value_t   digest;
  count64_t fold_count;
  count64_t experts_total;
  pend_t    pending_bits;

  modport source (output valid, output digest, output fold_count,
                  output experts_total, output pending_bits, input ready);
  modport sink   (input valid, input digest, input fold_count,
                  input experts_total, input pending_bits, output ready);
endinterface

### hw/rtl/rmfd_fold_unit.sv
// one fnv-1a byte step: xor the byte in, multiply by the fnv prime mod 2^64
module rmfd_fold_unit import rmfd_pkg::*; (
  input  value_t     hash_i,
  input  logic [7:0] byte_i,
  output value_t     hash_o
);

  value_t x;

  // xor the byte into the low bits
  assign x = hash_i ^ {{(VAL_W-8){1'b0}}, byte_i};

  // prime 0x100000001b3 = 2^40 + 0x1b3, and 0x1b3 = 2^8+2^7+2^5+2^4+2^1+2^0
  assign hash_o = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4)
                + (x << 1) + x;

endmodule

### hw/rtl/routing_mask_fnv_digest_unit.sv
// top level: one item folds one byte per cycle through a shared fnv step unit.
// the result register is loaded after the last byte of the item has been folded, once it is free.
// a new item is accepted only when idle, after every byte of the previous item has passed through the byte-fold unit.
// the result register frees the input side; a full result register stalls the commit.
// reset: synchronous active-low; digest returns to the fnv offset basis, counters clear.
`include "routing_mask_fnv_digest_unit_macros.svh"
module routing_mask_fnv_digest_unit import rmfd_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  rmfd_in_if.sink    in_ch,
  rmfd_out_if.source out_ch
);

  st_t                state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  action_t            act_r, act_nxt;
  value_t             val_r, val_nxt;
  value_t             hash_r, hash_nxt;
  count64_t           folds_r, folds_nxt;
  count64_t           sum_r, sum_nxt;
  pend_t              open_r, open_nxt;
  logic [IBITS_W-1:0] ibits_r, ibits_nxt;
  logic               out_valid_r, out_valid_nxt;
  value_t             out_digest_r;
  count64_t           out_folds_r;
  count64_t           out_sum_r;
  pend_t              out_pend_r;

  value_t             fold_hash;
  value_t             digest_sel;
  logic [IBITS_W-1:0] ibits_add;
  logic [PEND_W:0]    pend_sum;
  logic               accept;
  logic               last;
  logic               out_free;
  logic               commit;
  logic               in_ready;
  logic               folding;

  // shared byte step
  rmfd_fold_unit u_fold (
    .hash_i (hash_r),
    .byte_i (val_r[7:0]),
    .hash_o (fold_hash)
  );

  assign accept   = in_ch.valid && in_ready;
  assign last     = (cnt_r == CNT_W'(BYTES - 1));
  assign out_free = !out_valid_r || out_ch.ready;
  assign commit   = ((state_r == ST_BUSY) && last && out_free)
                 || ((state_r == ST_HOLD) && out_free);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_BUSY;
      end
      ST_BUSY: begin
        if (last) state_nxt = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state decoded controls
  always_comb begin
    in_ready = 1'b0;
    folding  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_BUSY: folding  = 1'b1;
      ST_HOLD: ;
      default: ;
    endcase
  end

  // item set bits, one byte per cycle; upper mask bytes are zero
  assign ibits_add = ibits_r + ((act_r == ACT_MASK) ? IBITS_W'(popcount8(val_r[7:0]))
                                                    : IBITS_W'(0));
  assign pend_sum  = {1'b0, open_r} + (PEND_W+1)'(ibits_add);

  // digest leaving with the result
  assign digest_sel = folding ? fold_hash : hash_r;

  // datapath and counter updates
  always_comb begin
    cnt_nxt   = cnt_r;
    act_nxt   = act_r;
    val_nxt   = val_r;
    hash_nxt  = hash_r;
    ibits_nxt = ibits_r;
    folds_nxt = folds_r;
    sum_nxt   = sum_r;
    open_nxt  = open_r;
    if (accept) begin
      cnt_nxt   = '0;
      act_nxt   = in_ch.action;
      val_nxt   = (in_ch.action == ACT_MASK) ? {{(VAL_W-MASK_W){1'b0}}, in_ch.value[MASK_W-1:0]}
                                             : in_ch.value;
      ibits_nxt = '0;
    end else if (folding) begin
      cnt_nxt   = cnt_r + CNT_W'(1);
      val_nxt   = val_r >> 8;
      hash_nxt  = fold_hash;
      ibits_nxt = ibits_add;
    end
    if (commit) begin
      case (act_r)
        ACT_MASK: begin
          open_nxt = (pend_sum > {1'b0, PEND_CAP}) ? PEND_CAP : pend_sum[PEND_W-1:0];
        end
        ACT_FOLD_END: begin
          sum_nxt   = sum_r + CNT64_W'(open_r);
          folds_nxt = folds_r + CNT64_W'(1);
          open_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hash_r      <= FNV_BASIS;
      folds_r     <= '0;
      sum_r       <= '0;
      open_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hash_r      <= hash_nxt;
      folds_r     <= folds_nxt;
      sum_r       <= sum_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item payload and result payload
  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    val_r   <= val_nxt;
    ibits_r <= ibits_nxt;
    if (commit) begin
      out_digest_r <= digest_sel;
      out_folds_r  <= folds_nxt;
      out_sum_r    <= sum_nxt;
      out_pend_r   <= open_nxt;
    end
  end

  assign in_ch.ready          = in_ready;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.digest        = out_digest_r;
  assign out_ch.fold_count    = out_folds_r;
  assign out_ch.experts_total = out_sum_r;
  assign out_ch.pending_bits  = out_pend_r;

  // checks
  `RMFD_ASSERT_NEXT(a_accept_starts, accept, state_r == ST_BUSY && cnt_r == '0,
                    "accept did not start byte folding")
  `RMFD_ASSERT_SAME(a_pend_cap, 1'b1, open_r <= PEND_CAP, "pending bit count above cap")
  `RMFD_ASSERT_NEXT(a_fold_close, commit && act_r == ACT_FOLD_END,
                    open_r == '0 && folds_r == $past(folds_r) + 64'd1,
                    "fold end did not close the fold")
  `RMFD_ASSERT_SAME(a_hold_full, state_r == ST_HOLD, out_valid_r,
                    "holding with an empty result register")

endmodule
